>>> rtl/ray_sphere_intersect_macros.svh
// assertion helpers shared by the checker
`ifndef RAY_SPHERE_INTERSECT_MACROS_SVH
`define RAY_SPHERE_INTERSECT_MACROS_SVH

// property that holds in the same cycle
`define RSI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property whose consequent is due in the next cycle
`define RSI_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) else $error(msg);

`endif

>>> rtl/rsi_pkg.sv
package rsi_pkg;

  localparam int COORD_W   = 32;
  localparam int DIR_W     = 16;
  localparam int RAD_W     = 31;
  localparam int CFG_IDX_W = 3;
  localparam int FRAC_DIR  = 14;
  localparam int SQRT_W    = 64;
  localparam int LEN_W     = SQRT_W / 2;
  localparam int QUO_W     = FRAC_DIR + 1;
  localparam int NUM_W     = LEN_W + FRAC_DIR + 1;
  localparam int LANES     = 3;

  localparam logic [RAD_W-1:0] RAD_RESET = 31'd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_X = 3'd0,
    CFG_CENTER_Y = 3'd1,
    CFG_CENTER_Z = 3'd2,
    CFG_RADIUS   = 3'd3
  } cfg_idx_t;

endpackage

>>> rtl/ray_sphere_intersect.sv
// throughput: one ray per cycle unless the output stalls; 17 single stages,
//   two 32-stage root pipes and a 15-stage divider, all advancing together
// a stalled output freezes the whole pipeline, bubbles included
// reset (synchronous, active low) clears all valid bits, centre to 0, radius to 1.0
module ray_sphere_intersect (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [rsi_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rsi_pkg::COORD_W-1:0]       cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [rsi_pkg::COORD_W-1:0] in_origin_x,
  input  logic signed [rsi_pkg::COORD_W-1:0] in_origin_y,
  input  logic signed [rsi_pkg::COORD_W-1:0] in_origin_z,
  input  logic signed [rsi_pkg::DIR_W-1:0]   in_dir_x,
  input  logic signed [rsi_pkg::DIR_W-1:0]   in_dir_y,
  input  logic signed [rsi_pkg::DIR_W-1:0]   in_dir_z,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_hit,
  output logic signed [rsi_pkg::COORD_W-1:0] out_point_x,
  output logic signed [rsi_pkg::COORD_W-1:0] out_point_y,
  output logic signed [rsi_pkg::COORD_W-1:0] out_point_z,
  output logic signed [rsi_pkg::DIR_W-1:0]   out_normal_x,
  output logic signed [rsi_pkg::DIR_W-1:0]   out_normal_y,
  output logic signed [rsi_pkg::DIR_W-1:0]   out_normal_z
);

  localparam int S1W = 1 + 37 + 3 * rsi_pkg::COORD_W + 3 * rsi_pkg::DIR_W;
  localparam int S2W = 1 + 6 * rsi_pkg::COORD_W + 3;
  localparam int S3W = 2 + 3 * rsi_pkg::COORD_W + 3;

  logic en;
  logic out_valid_r;

  assign en       = out_ready | ~out_valid_r;
  assign in_ready = en;

  // configuration
  logic signed [31:0] ctr_r [3];
  logic [30:0]        rad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctr_r[0] <= '0;
      ctr_r[1] <= '0;
      ctr_r[2] <= '0;
      rad_r    <= rsi_pkg::RAD_RESET;
    end else if (cfg_we) begin
      case (rsi_pkg::cfg_idx_t'(cfg_index))
        rsi_pkg::CFG_CENTER_X: ctr_r[0] <= cfg_wdata;
        rsi_pkg::CFG_CENTER_Y: ctr_r[1] <= cfg_wdata;
        rsi_pkg::CFG_CENTER_Z: ctr_r[2] <= cfg_wdata;
        rsi_pkg::CFG_RADIUS:   rad_r    <= cfg_wdata[30:0];
        default: ;
      endcase
    end
  end

  logic signed [31:0] org_in [3];
  logic signed [15:0] dir_in [3];

  assign org_in[0] = in_origin_x;
  assign org_in[1] = in_origin_y;
  assign org_in[2] = in_origin_z;
  assign dir_in[0] = in_dir_x;
  assign dir_in[1] = in_dir_y;
  assign dir_in[2] = in_dir_z;

  // valid chain
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r, v8_r;
  logic v9_r, v10_r, v11_r, v12_r, v13_r, v14_r, v15_r, v16_r;
  logic v_sq1, v_sq2, v_dv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      v6_r        <= 1'b0;
      v7_r        <= 1'b0;
      v8_r        <= 1'b0;
      v9_r        <= 1'b0;
      v10_r       <= 1'b0;
      v11_r       <= 1'b0;
      v12_r       <= 1'b0;
      v13_r       <= 1'b0;
      v14_r       <= 1'b0;
      v15_r       <= 1'b0;
      v16_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r        <= in_valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      v5_r        <= v4_r;
      v6_r        <= v5_r;
      v7_r        <= v6_r;
      v8_r        <= v7_r;
      v9_r        <= v_sq1;
      v10_r       <= v9_r;
      v11_r       <= v10_r;
      v12_r       <= v11_r;
      v13_r       <= v12_r;
      v14_r       <= v13_r;
      v15_r       <= v14_r;
      v16_r       <= v_sq2;
      out_valid_r <= v_dv;
    end
  end

  // front end: offset, dot product, squared distance, closest approach, hit test
  logic signed [32:0] l1_r    [3];
  logic signed [31:0] o1_r    [3];
  logic signed [15:0] d1_r    [3];
  logic [32:0]        lmag1   [3];
  logic signed [48:0] prod2_r [3];
  logic [65:0]        sq2_r   [3];
  logic signed [31:0] o2_r    [3];
  logic signed [15:0] d2_r    [3];
  logic signed [50:0] dot3_r;
  logic [65:0]        ll3_r;
  logic signed [31:0] o3_r    [3];
  logic signed [15:0] d3_r    [3];
  logic signed [50:0] tsum3;
  logic               miss4_r;
  logic [36:0]        t4_r;
  logic [65:0]        ll4_r;
  logic signed [31:0] o4_r    [3];
  logic signed [15:0] d4_r    [3];
  logic [33:0]        phh5_r;
  logic [36:0]        phl5_r;
  logic [39:0]        pll5_r;
  logic [61:0]        r25_r;
  logic               miss5_r;
  logic [36:0]        t5_r;
  logic [65:0]        ll5_r;
  logic signed [31:0] o5_r    [3];
  logic signed [15:0] d5_r    [3];
  logic [73:0]        tt6_r;
  logic [61:0]        r26_r;
  logic               miss6_r;
  logic [36:0]        t6_r;
  logic [65:0]        ll6_r;
  logic signed [31:0] o6_r    [3];
  logic signed [15:0] d6_r    [3];
  logic [65:0]        h27_r;
  logic [61:0]        r27_r;
  logic               miss7_r;
  logic [36:0]        t7_r;
  logic signed [31:0] o7_r    [3];
  logic signed [15:0] d7_r    [3];
  logic               hit8_r;
  logic [61:0]        rad8_r;
  logic [36:0]        t8_r;
  logic signed [31:0] o8_r    [3];
  logic signed [15:0] d8_r    [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lmag1[i] = l1_r[i][32] ? 33'(-l1_r[i]) : 33'(l1_r[i]);
    end
    tsum3 = dot3_r + 51'sd8192;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        l1_r[i]    <= 33'(ctr_r[i]) - 33'(org_in[i]);
        o1_r[i]    <= org_in[i];
        d1_r[i]    <= dir_in[i];
        prod2_r[i] <= l1_r[i] * d1_r[i];
        sq2_r[i]   <= 66'(lmag1[i]) * 66'(lmag1[i]);
        o2_r[i]    <= o1_r[i];
        d2_r[i]    <= d1_r[i];
        o3_r[i]    <= o2_r[i];
        d3_r[i]    <= d2_r[i];
        o4_r[i]    <= o3_r[i];
        d4_r[i]    <= d3_r[i];
        o5_r[i]    <= o4_r[i];
        d5_r[i]    <= d4_r[i];
        o6_r[i]    <= o5_r[i];
        d6_r[i]    <= d5_r[i];
        o7_r[i]    <= o6_r[i];
        d7_r[i]    <= d6_r[i];
        o8_r[i]    <= o7_r[i];
        d8_r[i]    <= d7_r[i];
      end
      dot3_r  <= 51'(prod2_r[0]) + 51'(prod2_r[1]) + 51'(prod2_r[2]);
      ll3_r   <= sq2_r[0] + sq2_r[1] + sq2_r[2];
      miss4_r <= dot3_r[50] | (dot3_r == '0);
      t4_r    <= tsum3[50:14];
      ll4_r   <= ll3_r;
      // t squared from three partial products
      phh5_r  <= t4_r[36:20] * t4_r[36:20];
      phl5_r  <= t4_r[36:20] * t4_r[19:0];
      pll5_r  <= t4_r[19:0] * t4_r[19:0];
      r25_r   <= rad_r * rad_r;
      miss5_r <= miss4_r;
      t5_r    <= t4_r;
      ll5_r   <= ll4_r;
      tt6_r   <= (74'(phh5_r) << 40) + (74'(phl5_r) << 21) + 74'(pll5_r);
      r26_r   <= r25_r;
      miss6_r <= miss5_r;
      t6_r    <= t5_r;
      ll6_r   <= ll5_r;
      h27_r   <= (74'(ll6_r) < tt6_r) ? 66'd0 : 66'(74'(ll6_r) - tt6_r);
      r27_r   <= r26_r;
      miss7_r <= miss6_r;
      t7_r    <= t6_r;
      hit8_r  <= !miss7_r && (h27_r < 66'(r27_r));
      rad8_r  <= (h27_r < 66'(r27_r)) ? (r27_r - h27_r[61:0]) : '0;
      t8_r    <= t7_r;
    end
  end

  // half chord length
  logic [S1W-1:0]     side1_in, side1_out;
  logic [31:0]        thc;
  logic               hit_a;
  logic [36:0]        t_a;
  logic signed [31:0] o_a [3];
  logic signed [15:0] d_a [3];

  assign side1_in = {hit8_r, t8_r, o8_r[0], o8_r[1], o8_r[2], d8_r[0], d8_r[1], d8_r[2]};
  assign {hit_a, t_a, o_a[0], o_a[1], o_a[2], d_a[0], d_a[1], d_a[2]} = side1_out;

  rsi_isqrt #(
    .W  (rsi_pkg::SQRT_W),
    .SW (S1W)
  ) u_sqrt_chord (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v8_r),
    .in_rad    ({2'b00, rad8_r}),
    .in_side   (side1_in),
    .out_valid (v_sq1),
    .out_root  (thc),
    .out_side  (side1_out)
  );

  // hit point and offset from the centre
  logic signed [37:0] s9_r;
  logic               hit9_r, hit10_r, hit11_r, hit12_r, hit13_r, hit14_r, hit15_r;
  logic signed [31:0] o9_r    [3];
  logic signed [15:0] d9_r    [3];
  logic signed [53:0] m10_r   [3];
  logic signed [31:0] o10_r   [3];
  logic signed [53:0] rnd10   [3];
  logic signed [40:0] p11_r   [3];
  logic [31:0]        psat11  [3];
  logic signed [41:0] df12_r  [3];
  logic [31:0]        ps12_r  [3];
  logic [41:0]        adf12   [3];
  logic [31:0]        mg13_r  [3];
  logic               sg13_r  [3];
  logic [31:0]        ps13_r  [3];
  logic [63:0]        sqe14_r [3];
  logic [31:0]        mg14_r  [3];
  logic               sg14_r  [3];
  logic [31:0]        ps14_r  [3];
  logic [63:0]        n215_r;
  logic [31:0]        mg15_r  [3];
  logic               sg15_r  [3];
  logic [31:0]        ps15_r  [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rnd10[i] = m10_r[i] + 54'sd8192;
      if (p11_r[i] > 41'sd2147483647) begin
        psat11[i] = 32'h7fff_ffff;
      end else if (p11_r[i] < -41'sd2147483648) begin
        psat11[i] = 32'h8000_0000;
      end else begin
        psat11[i] = p11_r[i][31:0];
      end
      adf12[i] = df12_r[i][41] ? 42'(-df12_r[i]) : 42'(df12_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s9_r    <= $signed({1'b0, t_a}) - $signed({6'd0, thc});
      hit9_r  <= hit_a;
      hit10_r <= hit9_r;
      hit11_r <= hit10_r;
      hit12_r <= hit11_r;
      hit13_r <= hit12_r;
      hit14_r <= hit13_r;
      hit15_r <= hit14_r;
      for (int i = 0; i < 3; i++) begin
        o9_r[i]    <= o_a[i];
        d9_r[i]    <= d_a[i];
        m10_r[i]   <= d9_r[i] * s9_r;
        o10_r[i]   <= o9_r[i];
        p11_r[i]   <= 41'(o10_r[i]) + 41'($signed(rnd10[i][53:14]));
        df12_r[i]  <= 42'(p11_r[i]) - 42'(ctr_r[i]);
        ps12_r[i]  <= psat11[i];
        mg13_r[i]  <= (adf12[i] > 42'd2147483648) ? 32'h8000_0000 : adf12[i][31:0];
        sg13_r[i]  <= df12_r[i][41];
        ps13_r[i]  <= ps12_r[i];
        sqe14_r[i] <= 64'(mg13_r[i]) * 64'(mg13_r[i]);
        mg14_r[i]  <= mg13_r[i];
        sg14_r[i]  <= sg13_r[i];
        ps14_r[i]  <= ps13_r[i];
        mg15_r[i]  <= mg14_r[i];
        sg15_r[i]  <= sg14_r[i];
        ps15_r[i]  <= ps14_r[i];
      end
      n215_r <= sqe14_r[0] + sqe14_r[1] + sqe14_r[2];
    end
  end

  // normal length
  logic [S2W-1:0] side2_in, side2_out;
  logic [31:0]    len_b;
  logic           hit_b;
  logic [31:0]    ps_b [3];
  logic [31:0]    mg_b [3];
  logic           sg_b [3];

  assign side2_in = {hit15_r, ps15_r[0], ps15_r[1], ps15_r[2],
                     mg15_r[0], mg15_r[1], mg15_r[2], sg15_r[0], sg15_r[1], sg15_r[2]};
  assign {hit_b, ps_b[0], ps_b[1], ps_b[2],
          mg_b[0], mg_b[1], mg_b[2], sg_b[0], sg_b[1], sg_b[2]} = side2_out;

  rsi_isqrt #(
    .W  (rsi_pkg::SQRT_W),
    .SW (S2W)
  ) u_sqrt_len (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v15_r),
    .in_rad    (n215_r),
    .in_side   (side2_in),
    .out_valid (v_sq2),
    .out_root  (len_b),
    .out_side  (side2_out)
  );

  // normal components by division
  logic [rsi_pkg::LANES-1:0][rsi_pkg::NUM_W-1:0] num16_r;
  logic [rsi_pkg::LANES-1:0][rsi_pkg::QUO_W-1:0] quo_c;
  logic [31:0]    len16_r;
  logic           hit16_r, lz16_r;
  logic [31:0]    ps16_r [3];
  logic           sg16_r [3];
  logic [S3W-1:0] side3_in, side3_out;
  logic           hit_c, lz_c;
  logic [31:0]    ps_c [3];
  logic           sg_c [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        num16_r[i] <= {1'b0, mg_b[i], 14'd0} + rsi_pkg::NUM_W'(len_b[31:1]);
        ps16_r[i]  <= ps_b[i];
        sg16_r[i]  <= sg_b[i];
      end
      len16_r <= len_b;
      hit16_r <= hit_b;
      lz16_r  <= (len_b == '0);
    end
  end

  assign side3_in = {hit16_r, lz16_r, ps16_r[0], ps16_r[1], ps16_r[2],
                     sg16_r[0], sg16_r[1], sg16_r[2]};
  assign {hit_c, lz_c, ps_c[0], ps_c[1], ps_c[2], sg_c[0], sg_c[1], sg_c[2]} = side3_out;

  rsi_div #(
    .NW (rsi_pkg::NUM_W),
    .DW (rsi_pkg::LEN_W),
    .QW (rsi_pkg::QUO_W),
    .SW (S3W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v16_r),
    .in_num    (num16_r),
    .in_den    (len16_r),
    .in_side   (side3_in),
    .out_valid (v_dv),
    .out_quo   (quo_c),
    .out_side  (side3_out)
  );

  // output register
  logic        hit_r;
  logic [31:0] pt_r  [3];
  logic [15:0] nrm_r [3];
  logic [15:0] nrm_nxt [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (hit_c && !lz_c) begin
        nrm_nxt[i] = sg_c[i] ? -16'(quo_c[i]) : 16'(quo_c[i]);
      end else begin
        nrm_nxt[i] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit_r <= hit_c;
      for (int i = 0; i < 3; i++) begin
        pt_r[i]  <= hit_c ? ps_c[i] : '0;
        nrm_r[i] <= nrm_nxt[i];
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign out_hit      = hit_r;
  assign out_point_x  = pt_r[0];
  assign out_point_y  = pt_r[1];
  assign out_point_z  = pt_r[2];
  assign out_normal_x = nrm_r[0];
  assign out_normal_y = nrm_r[1];
  assign out_normal_z = nrm_r[2];

endmodule

>>> rtl/rsi_isqrt.sv
module rsi_isqrt #(
  parameter int W  = rsi_pkg::SQRT_W,
  parameter int SW = 1
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_valid,
  input  logic [W-1:0]   in_rad,
  input  logic [SW-1:0]  in_side,
  output logic           out_valid,
  output logic [W/2-1:0] out_root,
  output logic [SW-1:0]  out_side
);

  localparam int N  = W / 2;
  localparam int RW = N + 3;

  logic          v_r    [N];
  logic [RW-1:0] rem_r  [N];
  logic [N-1:0]  root_r [N];
  logic [W-1:0]  x_r    [N];
  logic [SW-1:0] side_r [N];

  for (genvar g = 0; g < N; g++) begin : g_stage
    logic          v_p;
    logic [RW-1:0] rem_p;
    logic [N-1:0]  root_p;
    logic [W-1:0]  x_p;
    logic [SW-1:0] side_p;
    logic [RW-1:0] cur;
    logic [RW-1:0] trial;
    logic [RW-1:0] rem_nxt;
    logic [N-1:0]  root_nxt;

    if (g == 0) begin : g_first
      assign v_p    = in_valid;
      assign rem_p  = '0;
      assign root_p = '0;
      assign x_p    = in_rad;
      assign side_p = in_side;
    end else begin : g_rest
      assign v_p    = v_r[g-1];
      assign rem_p  = rem_r[g-1];
      assign root_p = root_r[g-1];
      assign x_p    = x_r[g-1];
      assign side_p = side_r[g-1];
    end

    // one root bit per stage
    always_comb begin
      cur   = {rem_p[RW-3:0], x_p[W-1 -: 2]};
      trial = RW'({root_p, 2'b01});
      if (cur >= trial) begin
        rem_nxt  = cur - trial;
        root_nxt = {root_p[N-2:0], 1'b1};
      end else begin
        rem_nxt  = cur;
        root_nxt = {root_p[N-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g] <= 1'b0;
      end else if (en) begin
        v_r[g] <= v_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g]  <= rem_nxt;
        root_r[g] <= root_nxt;
        x_r[g]    <= {x_p[W-3:0], 2'b00};
        side_r[g] <= side_p;
      end
    end
  end

  assign out_valid = v_r[N-1];
  assign out_root  = root_r[N-1];
  assign out_side  = side_r[N-1];

endmodule

>>> rtl/rsi_div.sv
module rsi_div #(
  parameter int NW = rsi_pkg::NUM_W,
  parameter int DW = rsi_pkg::LEN_W,
  parameter int QW = rsi_pkg::QUO_W,
  parameter int SW = 1
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  logic                               in_valid,
  input  logic [rsi_pkg::LANES-1:0][NW-1:0] in_num,
  input  logic [DW-1:0]                      in_den,
  input  logic [SW-1:0]                      in_side,
  output logic                               out_valid,
  output logic [rsi_pkg::LANES-1:0][QW-1:0] out_quo,
  output logic [SW-1:0]                      out_side
);

  localparam int LN = rsi_pkg::LANES;

  logic                  v_r    [QW];
  logic [LN-1:0][NW-1:0] num_r  [QW];
  logic [LN-1:0][QW-1:0] quo_r  [QW];
  logic [DW-1:0]         den_r  [QW];
  logic [SW-1:0]         side_r [QW];

  for (genvar g = 0; g < QW; g++) begin : g_stage
    logic                  v_p;
    logic [LN-1:0][NW-1:0] num_p;
    logic [LN-1:0][QW-1:0] quo_p;
    logic [DW-1:0]         den_p;
    logic [SW-1:0]         side_p;
    logic [NW-1:0]         dsh;
    logic [LN-1:0][NW-1:0] num_nxt;
    logic [LN-1:0][QW-1:0] quo_nxt;

    if (g == 0) begin : g_first
      assign v_p    = in_valid;
      assign num_p  = in_num;
      assign quo_p  = '0;
      assign den_p  = in_den;
      assign side_p = in_side;
    end else begin : g_rest
      assign v_p    = v_r[g-1];
      assign num_p  = num_r[g-1];
      assign quo_p  = quo_r[g-1];
      assign den_p  = den_r[g-1];
      assign side_p = side_r[g-1];
    end

    // restoring step, quotient bits msb first
    assign dsh = NW'(den_p) << (QW - 1 - g);

    always_comb begin
      for (int l = 0; l < LN; l++) begin
        if (num_p[l] >= dsh) begin
          num_nxt[l] = num_p[l] - dsh;
          quo_nxt[l] = {quo_p[l][QW-2:0], 1'b1};
        end else begin
          num_nxt[l] = num_p[l];
          quo_nxt[l] = {quo_p[l][QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g] <= 1'b0;
      end else if (en) begin
        v_r[g] <= v_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        num_r[g]  <= num_nxt;
        quo_r[g]  <= quo_nxt;
        den_r[g]  <= den_p;
        side_r[g] <= side_p;
      end
    end
  end

  assign out_valid = v_r[QW-1];
  assign out_quo   = quo_r[QW-1];
  assign out_side  = side_r[QW-1];

endmodule

>>> rtl/rsi_checker.sv
`include "ray_sphere_intersect_macros.svh"

module rsi_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic                               out_hit,
  input logic signed [rsi_pkg::COORD_W-1:0] out_point_x,
  input logic signed [rsi_pkg::COORD_W-1:0] out_point_y,
  input logic signed [rsi_pkg::COORD_W-1:0] out_point_z,
  input logic signed [rsi_pkg::DIR_W-1:0]   out_normal_x,
  input logic signed [rsi_pkg::DIR_W-1:0]   out_normal_y,
  input logic signed [rsi_pkg::DIR_W-1:0]   out_normal_z
);

  // input side only stalls behind a blocked result
  `RSI_ASSERT(a_stall_cause, !in_ready |-> (out_valid && !out_ready), "input stalled without cause")

  `RSI_ASSERT(a_miss_point, (out_valid && !out_hit) |-> (out_point_x == 0 && out_point_y == 0 && out_point_z == 0), "miss with point")

  `RSI_ASSERT(a_miss_normal, (out_valid && !out_hit) |-> (out_normal_x == 0 && out_normal_y == 0 && out_normal_z == 0), "miss with normal")

  `RSI_ASSERT_NEXT(a_out_hold, (out_valid && !out_ready), (out_valid && $stable(out_point_x) && $stable(out_normal_x)), "result changed while stalled")

endmodule

bind ray_sphere_intersect rsi_checker u_rsi_checker (.*);
